>>> hdl/ucp_pkg.sv
// ucp_pkg: shared types and constants of the uri component parser
// parse phases, component kinds, verdict codes, result record, character class
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ucp_pkg;

	typedef enum logic [14:0] {
		PH_FIRST          = 15'h0001,
		PH_SCHEME_OR_PORT = 15'h0002,
		PH_SLASH2         = 15'h0004,
		PH_AUTH_START     = 15'h0008,
		PH_AUTH           = 15'h0010,
		PH_HOST_START     = 15'h0020,
		PH_HOST           = 15'h0040,
		PH_PORT_START     = 15'h0080,
		PH_PORT           = 15'h0100,
		PH_PATH           = 15'h0200,
		PH_QUERY_START    = 15'h0400,
		PH_QUERY          = 15'h0800,
		PH_FRAG_START     = 15'h1000,
		PH_FRAG           = 15'h2000,
		PH_DEAD           = 15'h4000
	} phase_t;

	localparam logic [2:0] K_NONE   = 3'd0;
	localparam logic [2:0] K_SCHEME = 3'd1;
	localparam logic [2:0] K_USER   = 3'd2;
	localparam logic [2:0] K_HOST   = 3'd3;
	localparam logic [2:0] K_PORT   = 3'd4;
	localparam logic [2:0] K_PATH   = 3'd5;
	localparam logic [2:0] K_QUERY  = 3'd6;
	localparam logic [2:0] K_FRAG   = 3'd7;

	localparam logic [1:0] ST_PARSING  = 2'd0;
	localparam logic [1:0] ST_ACCEPTED = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;

	// saturation point of the port accumulator
	localparam logic [16:0] PORT_CAP = 17'd65536;

	// result queue depth, entries
	localparam int unsigned QDEPTH = 4;

	typedef struct packed {
		logic [2:0]  comp_kind;
		logic [11:0] comp_start;
		logic [12:0] comp_end;
		logic [15:0] port_value;
		logic [1:0]  status;
		logic        is_last;
	} res_t;

	function automatic logic char_valid(input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39))
			ok = 1'b1;
		case (c)
			8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h21, 8'h2A, 8'h27, 8'h28, 8'h29,
			8'h3B, CH_COLON, CH_AT, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C,
			CH_SLASH, CH_QUEST, CH_HASH, 8'h5B, 8'h5D, CH_PCT: ok = 1'b1;
			default: ;
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ucp_core.sv
// ucp_core: parse state registers and the per-character transition logic
// produces up to two result records per accepted character; uses ucp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucp_core import ucp_pkg::*; #(
	parameter int unsigned MAX_LEN = 4096
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] ch,
	input  wire logic       is_end,
	output res_t            res0,
	output res_t            res1,
	output logic [1:0]      n_res
);

	localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] tok_q, tok_d;
	logic [POS_W-1:0] colon_q, colon_d;
	logic             colon_seen_q, colon_seen_d;
	logic [16:0]      acc_q, acc_d;
	logic             stopped_q, stopped_d;
	logic             dseen_q, dseen_d;

	logic        is_dig;
	logic        v;
	logic [19:0] acc_sum;
	logic [16:0] acc_add;
	logic [16:0] acc_first;
	logic        port_ok;
	logic        bad;
	logic [1:0]  st;

	function automatic res_t mk(input logic [2:0] k, input logic [POS_W-1:0] s,
		input logic [POS_W-1:0] e, input logic [16:0] pv);
		res_t r;
		logic [POS_W+12:0] se;
		logic [POS_W+12:0] ee;
		se = {13'd0, s};
		ee = {13'd0, e};
		r = '0;
		r.comp_kind  = k;
		r.comp_start = se[11:0];
		r.comp_end   = ee[12:0];
		r.port_value = pv[15:0];
		return r;
	endfunction

	assign is_dig    = (ch >= 8'h30) && (ch <= 8'h39);
	assign v         = char_valid(ch);
	assign acc_sum   = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {16'd0, ch[3:0]};
	assign acc_add   = (acc_sum > {3'd0, PORT_CAP}) ? PORT_CAP : acc_sum[16:0];
	assign acc_first = {13'd0, ch[3:0]};
	assign port_ok   = dseen_q && !acc_q[16];

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		tok_d        = tok_q;
		colon_d      = colon_q;
		colon_seen_d = colon_seen_q;
		acc_d        = acc_q;
		stopped_d    = stopped_q;
		dseen_d      = dseen_q;
		res0         = '0;
		res1         = '0;
		n_res        = 2'd0;
		bad          = 1'b0;
		st           = ST_PARSING;

		if (fire) begin
			if (is_end) begin
				case (phase_q)
					PH_FIRST: begin
						if (pos_q == '0) bad = 1'b1;
						else begin
							res0 = mk(K_HOST, tok_q, pos_q, '0);
							n_res = 2'd1;
						end
					end
					PH_AUTH: begin
						if (colon_seen_q) begin
							if (!port_ok) bad = 1'b1;
							else begin
								res0 = mk(K_HOST, tok_q, colon_q, '0);
								res1 = mk(K_PORT, colon_q + 1'b1, pos_q, acc_q);
								n_res = 2'd2;
							end
						end else begin
							res0 = mk(K_HOST, tok_q, pos_q, '0);
							n_res = 2'd1;
						end
					end
					PH_HOST: begin
						res0 = mk(K_HOST, tok_q, pos_q, '0);
						n_res = 2'd1;
					end
					PH_PORT: begin
						if (port_ok) begin
							res0 = mk(K_PORT, tok_q, pos_q, acc_q);
							n_res = 2'd1;
						end else bad = 1'b1;
					end
					PH_PATH: begin
						res0 = mk(K_PATH, tok_q, pos_q, '0);
						n_res = 2'd1;
					end
					PH_QUERY: begin
						res0 = mk(K_QUERY, tok_q, pos_q, '0);
						n_res = 2'd1;
					end
					PH_FRAG: begin
						res0 = mk(K_FRAG, tok_q, pos_q, '0);
						n_res = 2'd1;
					end
					default: bad = 1'b1;
				endcase
				st = bad ? ST_REJECTED : ST_ACCEPTED;
			end else if (phase_q == PH_DEAD) begin
				// dead until the end marker
			end else if (pos_q >= POS_MAX) begin
				bad = 1'b1;
			end else begin
				case (phase_q)
					PH_FIRST: begin
						if (ch == CH_SLASH) begin
							res0 = mk(K_HOST, tok_q, pos_q, '0);
							n_res = 2'd1;
							tok_d = pos_q;
							phase_d = PH_PATH;
						end else if (ch == CH_COLON) begin
							colon_d = pos_q;
							phase_d = PH_SCHEME_OR_PORT;
						end else if (ch == CH_QUEST || ch == CH_HASH || !v) begin
							bad = 1'b1;
						end
					end
					PH_SCHEME_OR_PORT: begin
						if (is_dig) begin
							res0 = mk(K_HOST, tok_q, colon_q, '0);
							n_res = 2'd1;
							acc_d = acc_first;
							stopped_d = 1'b0;
							dseen_d = 1'b1;
							tok_d = pos_q;
							phase_d = PH_PORT;
						end else begin
							res0 = mk(K_SCHEME, tok_q, colon_q, '0);
							n_res = 2'd1;
							if (ch == CH_SLASH) phase_d = PH_SLASH2;
							else if (ch == CH_QUEST) phase_d = PH_QUERY_START;
							else if (ch == CH_HASH) phase_d = PH_FRAG_START;
							else bad = 1'b1;
						end
					end
					PH_SLASH2: begin
						if (ch == CH_SLASH) phase_d = PH_AUTH_START;
						else bad = 1'b1;
					end
					PH_AUTH_START: begin
						if (ch == CH_SLASH) begin
							tok_d = pos_q;
							phase_d = PH_PATH;
						end else if (ch == CH_AT || !v) begin
							bad = 1'b1;
						end else begin
							tok_d = pos_q;
							colon_seen_d = (ch == CH_COLON);
							colon_d = pos_q;
							acc_d = '0;
							stopped_d = 1'b0;
							dseen_d = 1'b0;
							phase_d = PH_AUTH;
						end
					end
					PH_AUTH: begin
						if (!v) begin
							bad = 1'b1;
						end else if (ch == CH_AT) begin
							res0 = mk(K_USER, tok_q, pos_q, '0);
							n_res = 2'd1;
							colon_seen_d = 1'b0;
							acc_d = '0;
							stopped_d = 1'b0;
							dseen_d = 1'b0;
							phase_d = PH_HOST_START;
						end else if (ch == CH_SLASH) begin
							if (colon_seen_q) begin
								if (!port_ok) bad = 1'b1;
								else begin
									res0 = mk(K_HOST, tok_q, colon_q, '0);
									res1 = mk(K_PORT, colon_q + 1'b1, pos_q, acc_q);
									n_res = 2'd2;
								end
							end else begin
								res0 = mk(K_HOST, tok_q, pos_q, '0);
								n_res = 2'd1;
							end
							tok_d = pos_q;
							phase_d = PH_PATH;
						end else if (!colon_seen_q) begin
							if (ch == CH_COLON) begin
								colon_seen_d = 1'b1;
								colon_d = pos_q;
							end
						end else if (!stopped_q) begin
							if (is_dig) begin
								acc_d = acc_add;
								dseen_d = 1'b1;
							end else stopped_d = 1'b1;
						end
					end
					PH_HOST_START: begin
						if (ch == CH_COLON || ch == CH_SLASH || !v) bad = 1'b1;
						else begin
							tok_d = pos_q;
							phase_d = PH_HOST;
						end
					end
					PH_HOST: begin
						if (!v) begin
							bad = 1'b1;
						end else if (ch == CH_COLON) begin
							res0 = mk(K_HOST, tok_q, pos_q, '0);
							n_res = 2'd1;
							phase_d = PH_PORT_START;
						end else if (ch == CH_SLASH) begin
							res0 = mk(K_HOST, tok_q, pos_q, '0);
							n_res = 2'd1;
							tok_d = pos_q;
							phase_d = PH_PATH;
						end
					end
					PH_PORT_START: begin
						if (is_dig) begin
							acc_d = acc_first;
							stopped_d = 1'b0;
							dseen_d = 1'b1;
							tok_d = pos_q;
							phase_d = PH_PORT;
						end else bad = 1'b1;
					end
					PH_PORT: begin
						if (is_dig) begin
							acc_d = acc_add;
							dseen_d = 1'b1;
						end else if (ch == CH_SLASH && port_ok) begin
							res0 = mk(K_PORT, tok_q, pos_q, acc_q);
							n_res = 2'd1;
							tok_d = pos_q;
							phase_d = PH_PATH;
						end else bad = 1'b1;
					end
					PH_PATH: begin
						if (!v) begin
							bad = 1'b1;
						end else if (ch == CH_QUEST || ch == CH_HASH) begin
							res0 = mk(K_PATH, tok_q, pos_q, '0);
							n_res = 2'd1;
							phase_d = (ch == CH_QUEST) ? PH_QUERY_START : PH_FRAG_START;
						end
					end
					PH_QUERY_START: begin
						if (ch == CH_HASH) begin
							res0 = mk(K_QUERY, pos_q, pos_q, '0);
							n_res = 2'd1;
							phase_d = PH_FRAG_START;
						end else if (!v) begin
							bad = 1'b1;
						end else begin
							tok_d = pos_q;
							phase_d = PH_QUERY;
						end
					end
					PH_QUERY: begin
						if (!v) begin
							bad = 1'b1;
						end else if (ch == CH_HASH) begin
							res0 = mk(K_QUERY, tok_q, pos_q, '0);
							n_res = 2'd1;
							phase_d = PH_FRAG_START;
						end
					end
					PH_FRAG_START: begin
						if (!v) bad = 1'b1;
						else begin
							tok_d = pos_q;
							phase_d = PH_FRAG;
						end
					end
					PH_FRAG: begin
						if (!v) bad = 1'b1;
					end
					default: bad = 1'b1;
				endcase
				pos_d = pos_q + 1'b1;
			end

			if (bad) begin
				n_res = 2'd0;
				st = ST_REJECTED;
				phase_d = PH_DEAD;
			end
			// verdict with nothing closed still gets one record
			if (st != ST_PARSING && n_res == 2'd0) begin
				res0 = '0;
				n_res = 2'd1;
			end
			res0.status  = st;
			res1.status  = st;
			res0.is_last = (n_res == 2'd1);
			res1.is_last = (n_res == 2'd2);

			if (is_end) begin
				phase_d      = PH_FIRST;
				pos_d        = '0;
				tok_d        = '0;
				colon_d      = '0;
				colon_seen_d = 1'b0;
				acc_d        = '0;
				stopped_d    = 1'b0;
				dseen_d      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			pos_q        <= '0;
			tok_q        <= '0;
			colon_q      <= '0;
			colon_seen_q <= 1'b0;
			acc_q        <= '0;
			stopped_q    <= 1'b0;
			dseen_q      <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			tok_q        <= tok_d;
			colon_q      <= colon_d;
			colon_seen_q <= colon_seen_d;
			acc_q        <= acc_d;
			stopped_q    <= stopped_d;
			dseen_q      <= dseen_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ucp_res_queue.sv
// ucp_res_queue: small result queue, takes up to two records per cycle, gives
// one while out_ready is high; uses ucp_pkg for the record type and depth
`timescale 1ns / 1ps
`default_nettype none

module ucp_res_queue import ucp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] n_push,
	input  res_t            push0,
	input  res_t            push1,
	output logic            room2,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_t            head
);

	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	res_t             entry_q [QDEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [PTR_W-1:0] wptr_p1;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = entry_q[rptr_q];
	assign room2     = (count_q <= CNT_W'(QDEPTH - 2));
	assign wptr_p1   = wptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) entry_q[wptr_q] <= push0;
		if (n_push == 2'd2) entry_q[wptr_p1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PTR_W'(n_push);
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

>>> hdl/uri_component_parser.sv
// uri_component_parser: top level, streaming uri splitter
// instantiates ucp_core and ucp_res_queue; uses ucp_pkg
//
// usage:
// - input channel (in_valid / in_ready): one character per transaction in ch;
//   a transaction with is_end high closes the string (ch is ignored) and the
//   parser returns to its start state for the next string
// - output channel (out_valid / out_ready): one result record per transaction;
//   a character that closes a component yields one or two records (host and
//   port close together), a rejecting character or the end marker yields at
//   least one record carrying the verdict, other characters yield none
// - is_last marks the final record of the character that produced it
// - records of a character are registered into the result queue at its
//   transaction; state update and record build happen in the same cycle
// - throughput: one character per cycle while in_ready is high; the limit is
//   the output side, which moves one record per cycle while out_ready is high,
//   via a four-entry queue; in_ready is high while it has room for two records
// - a stalled receiver drops in_ready once the queue has room for fewer than two; nothing is lost
// - reset (arst_n low) puts the parser at the first token, clears the character
//   position and the port accumulator, and empties the result queue
// - strings longer than MAX_LEN characters are rejected
`timescale 1ns / 1ps
`default_nettype none

module uri_component_parser import ucp_pkg::*; #(
	parameter int unsigned MAX_LEN = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	input  wire logic        is_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       comp_kind,
	output logic [11:0]      comp_start,
	output logic [12:0]      comp_end,
	output logic [15:0]      port_value,
	output logic [1:0]       status,
	output logic             is_last
);

	logic       fire;
	logic       room2;
	res_t       res0;
	res_t       res1;
	logic [1:0] n_res;
	res_t       head;

	// accept only while the queue can absorb the worst case of two records
	assign in_ready = room2;
	assign fire     = in_valid && in_ready;

	ucp_core #(
		.MAX_LEN(MAX_LEN)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (ch),
		.is_end (is_end),
		.res0   (res0),
		.res1   (res1),
		.n_res  (n_res)
	);

	ucp_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_push    (n_res),
		.push0     (res0),
		.push1     (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// record fields straight from the queue head
	assign comp_kind  = head.comp_kind;
	assign comp_start = head.comp_start;
	assign comp_end   = head.comp_end;
	assign port_value = head.port_value;
	assign status     = head.status;
	assign is_last    = head.is_last;

endmodule

`default_nettype wire
